### design/afd_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// afd_pkg: shared types and constants of the accelerometer frame decoder
// Word formats, register map, status codes and burst-group constants.
// ------------------------------------------------------------------------
package afd_pkg;

	// Largest number of samples decoded in one burst.
	localparam int MaxBurstSamples = 32;
	localparam int CountW          = $clog2(MaxBurstSamples + 1);

	// Byte positions within one nine-byte x,y,z group.
	localparam int PosW = 4;
	localparam logic [PosW-1:0] POS_X_HIGH  = 4'd0;
	localparam logic [PosW-1:0] POS_X_MID   = 4'd1;
	localparam logic [PosW-1:0] POS_X_LOW   = 4'd2;
	localparam logic [PosW-1:0] POS_Y_HIGH  = 4'd3;
	localparam logic [PosW-1:0] POS_Y_MID   = 4'd4;
	localparam logic [PosW-1:0] POS_Y_LOW   = 4'd5;
	localparam logic [PosW-1:0] POS_Z_HIGH  = 4'd6;
	localparam logic [PosW-1:0] POS_Z_MID   = 4'd7;
	localparam logic [PosW-1:0] POS_Z_LOW   = 4'd8;

	// Marker bits in the low nibble of each third byte.
	localparam int EmptyMarkBit = 1;
	localparam int XAxisMarkBit = 0;

	// Result status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_DATA = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	// Configuration port.
	localparam int ApbAddrW  = 3;
	localparam int ApbDataW  = 32;
	localparam logic REG_FIFO_MODE    = 1'b0;
	localparam logic REG_SAMPLE_LIMIT = 1'b1;
	localparam logic [CountW-1:0] SAMPLE_LIMIT_RESET = CountW'(32);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       burst_start;
	} in_word_t;

	typedef struct packed {
		logic signed [19:0] x_accel;
		logic signed [19:0] y_accel;
		logic signed [19:0] z_accel;
		logic [1:0]         status;
		logic [4:0]         sample_index;
	} out_word_t;

	typedef struct packed {
		logic              fifo_mode;
		logic [CountW-1:0] sample_limit;
	} cfg_t;

endpackage

### design/afd_cfg_regs.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// afd_cfg_regs: configuration register file
// APB-style write and read access to the mode and sample-limit registers.
// ------------------------------------------------------------------------
module afd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [afd_pkg::ApbAddrW-1:0]     paddr,
	input  logic [afd_pkg::ApbDataW-1:0]     pwdata,
	output logic [afd_pkg::ApbDataW-1:0]     prdata,
	output logic                             pready,
	output afd_pkg::cfg_t                    cfg
);

	logic                         fifo_mode_q;
	logic [afd_pkg::CountW-1:0]   sample_limit_q;
	logic                         wr_en;
	logic                         reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_mode_q    <= 1'b1;
			sample_limit_q <= afd_pkg::SAMPLE_LIMIT_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				afd_pkg::REG_FIFO_MODE:    fifo_mode_q    <= pwdata[0];
				afd_pkg::REG_SAMPLE_LIMIT: sample_limit_q <= pwdata[afd_pkg::CountW-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (reg_sel)
			afd_pkg::REG_FIFO_MODE:
				prdata = {{(afd_pkg::ApbDataW-1){1'b0}}, fifo_mode_q};
			afd_pkg::REG_SAMPLE_LIMIT:
				prdata = {{(afd_pkg::ApbDataW-afd_pkg::CountW){1'b0}}, sample_limit_q};
			default:
				prdata = '0;
		endcase
	end

	assign cfg.fifo_mode    = fifo_mode_q;
	assign cfg.sample_limit = sample_limit_q;

endmodule

### design/afd_unpack.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// afd_unpack: byte unpacker and marker checker
// Collects bytes into 20-bit axis values, tracks burst state and forms
// one result per completed nine-byte group.
// ------------------------------------------------------------------------
module afd_unpack (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  afd_pkg::in_word_t  in_word,
	input  afd_pkg::cfg_t      cfg,
	output logic               res_valid,
	output afd_pkg::out_word_t res_word
);

	logic [afd_pkg::PosW-1:0]   pos_q;
	logic [afd_pkg::CountW-1:0] count_q;
	logic                       empty_q;
	logic                       bad_q;
	logic                       halted_q;
	logic [7:0]                 high_q;
	logic [7:0]                 mid_q;
	logic [19:0]                x_hold_q;
	logic [19:0]                y_hold_q;

	logic [afd_pkg::PosW-1:0]   pos_eff;
	logic [afd_pkg::CountW-1:0] count_eff;
	logic                       empty_eff;
	logic                       bad_eff;
	logic                       active;
	logic [7:0]                 b;
	logic                       is_x;
	logic                       empty_nxt;
	logic                       bad_nxt;
	logic [19:0]                value;
	logic                       group_done;
	logic [1:0]                 status;
	logic [afd_pkg::CountW-1:0] count_nxt;
	logic [afd_pkg::CountW-1:0] limit;
	logic                       halt_nxt;

	assign b = in_word.data_byte;

	// A burst start clears the burst state before the byte is taken.
	assign pos_eff   = in_word.burst_start ? '0 : pos_q;
	assign count_eff = in_word.burst_start ? '0 : count_q;
	assign empty_eff = in_word.burst_start ? 1'b0 : empty_q;
	assign bad_eff   = in_word.burst_start ? 1'b0 : bad_q;
	assign active    = in_word.burst_start | ~halted_q;

	assign is_x  = b[afd_pkg::XAxisMarkBit];
	assign value = {high_q, mid_q, b[7:4]};

	// Marker checks on the third byte of each axis.
	always_comb begin
		empty_nxt = empty_eff;
		bad_nxt   = bad_eff;
		case (pos_eff)
			afd_pkg::POS_X_LOW: begin
				empty_nxt = empty_eff | b[afd_pkg::EmptyMarkBit];
				bad_nxt   = bad_eff | ~is_x;
			end
			afd_pkg::POS_Y_LOW, afd_pkg::POS_Z_LOW: begin
				empty_nxt = empty_eff | b[afd_pkg::EmptyMarkBit];
				bad_nxt   = bad_eff | is_x;
			end
			default: ;
		endcase
	end

	assign group_done = (pos_eff == afd_pkg::POS_Z_LOW);

	// Status: no_data wins over invalid_sample; plain register mode is always ok.
	always_comb begin
		if (!cfg.fifo_mode) begin
			status = afd_pkg::STATUS_OK;
		end else if (empty_nxt) begin
			status = afd_pkg::STATUS_NO_DATA;
		end else if (bad_nxt) begin
			status = afd_pkg::STATUS_INVALID;
		end else begin
			status = afd_pkg::STATUS_OK;
		end
	end

	// Effective sample limit: zero acts as one, large values saturate.
	always_comb begin
		if (cfg.sample_limit == '0) begin
			limit = afd_pkg::CountW'(1);
		end else if (cfg.sample_limit > afd_pkg::CountW'(afd_pkg::MaxBurstSamples)) begin
			limit = afd_pkg::CountW'(afd_pkg::MaxBurstSamples);
		end else begin
			limit = cfg.sample_limit;
		end
	end

	assign count_nxt = count_eff + afd_pkg::CountW'(1);
	assign halt_nxt  = (status != afd_pkg::STATUS_OK) | ~cfg.fifo_mode | (count_nxt >= limit);

	// Result word formed from the held axis values and the final byte.
	assign res_valid = accept & active & group_done;
	always_comb begin
		if (status == afd_pkg::STATUS_OK) begin
			res_word.x_accel = $signed(x_hold_q);
			res_word.y_accel = $signed(y_hold_q);
			res_word.z_accel = $signed(value);
		end else begin
			res_word.x_accel = '0;
			res_word.y_accel = '0;
			res_word.z_accel = '0;
		end
		res_word.status       = status;
		res_word.sample_index = count_eff[4:0];
	end

	// Burst control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			count_q  <= '0;
			empty_q  <= 1'b0;
			bad_q    <= 1'b0;
			halted_q <= 1'b1;
		end else if (accept && active) begin
			if (group_done) begin
				pos_q    <= '0;
				count_q  <= count_nxt;
				empty_q  <= 1'b0;
				bad_q    <= 1'b0;
				halted_q <= halt_nxt;
			end else begin
				pos_q    <= pos_eff + afd_pkg::PosW'(1);
				count_q  <= count_eff;
				empty_q  <= empty_nxt;
				bad_q    <= bad_nxt;
				halted_q <= 1'b0;
			end
		end
	end

	// Byte and axis value holding registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q   <= '0;
			mid_q    <= '0;
			x_hold_q <= '0;
			y_hold_q <= '0;
		end else if (accept && active) begin
			case (pos_eff)
				afd_pkg::POS_X_HIGH, afd_pkg::POS_Y_HIGH, afd_pkg::POS_Z_HIGH: high_q <= b;
				afd_pkg::POS_X_MID, afd_pkg::POS_Y_MID, afd_pkg::POS_Z_MID:    mid_q  <= b;
				afd_pkg::POS_X_LOW: x_hold_q <= value;
				afd_pkg::POS_Y_LOW: y_hold_q <= value;
				default: ;
			endcase
		end
	end

endmodule

### design/afd_out_reg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// afd_out_reg: result output register
// Holds one finished word until the consumer takes it.
// ------------------------------------------------------------------------
module afd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  afd_pkg::out_word_t load_word,
	output logic               out_valid,
	input  logic               out_ready,
	output afd_pkg::out_word_t out_word
);

	logic               valid_q;
	afd_pkg::out_word_t word_q;

	// Valid flag: set by a new word, cleared when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

### design/accel_fifo_frame_decoder.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// accel_fifo_frame_decoder: accelerometer burst byte unpacker
// A result word appears in the cycle after the ninth byte of a group is taken.
// Throughput: one byte per cycle; the single output register refills in the
// cycle it is read, so input stalls only while an unread word waits.
// Reset: burst state clears and the decoder waits for a burst start; fifo_mode
// resets to 1 and the per-burst sample limit to 32.
// ------------------------------------------------------------------------
module accel_fifo_frame_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  afd_pkg::in_word_t                in_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output afd_pkg::out_word_t               out_word,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [afd_pkg::ApbAddrW-1:0]     paddr,
	input  logic [afd_pkg::ApbDataW-1:0]     pwdata,
	output logic [afd_pkg::ApbDataW-1:0]     prdata,
	output logic                             pready
);

	afd_pkg::cfg_t      cfg;
	afd_pkg::out_word_t res_word;
	logic               res_valid;
	logic               accept;

	// A byte is taken whenever the output register is free or being read.
	assign in_ready = ~out_valid | out_ready;
	assign accept   = in_valid & in_ready;

	afd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	afd_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_word   (in_word),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

	afd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_word (res_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

### sim/afd_sample_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// afd_sample_checker: sample predictor and scoreboard for the frame decoder
// Watches the byte, sample and register channels, decodes every accepted
// byte into the x,y,z samples the decoder should emit, and compares each
// accepted sample word field by field against the oldest prediction.
// ------------------------------------------------------------------------
module afd_sample_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  afd_pkg::in_word_t            in_word,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  afd_pkg::out_word_t           out_word,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [afd_pkg::ApbAddrW-1:0] paddr,
	input  logic [afd_pkg::ApbDataW-1:0] pwdata,
	input  logic [afd_pkg::ApbDataW-1:0] prdata,
	input  logic                         pready,
	output int                           failures,
	output int                           pending
);
	import afd_pkg::*;

	// Register copies.
	logic              mode_fifo;
	logic [CountW-1:0] limit_raw;

	// Burst decode state.
	logic [PosW-1:0]   byte_pos;
	logic [7:0]        high_hold;
	logic [7:0]        mid_hold;
	logic [19:0]       x_hold;
	logic [19:0]       y_hold;
	logic              saw_empty;
	logic              saw_bad_marker;
	logic              halted;
	logic [CountW-1:0] samples_done;

	out_word_t expected_samples[$];
	int        fail_count = 0;
	int        waiting    = 0;

	assign failures = fail_count;
	assign pending  = waiting;

	// One axis value: high byte, middle byte and the upper nibble of the third.
	function automatic logic [19:0] axis_value(input logic [7:0] hi, input logic [7:0] mid,
		input logic [7:0] third);
		return {hi, mid, third[7:4]};
	endfunction

	// A limit of zero acts as one, and large limits saturate.
	function automatic int burst_limit(input logic [CountW-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MaxBurstSamples)
			return MaxBurstSamples;
		return int'(raw);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// Advance the burst decode by one accepted byte; queue a sample when a group closes.
	task automatic decode_byte(input in_word_t w);
		logic [7:0]  b;
		logic [1:0]  st;
		out_word_t   s;
		b = w.data_byte;
		if (w.burst_start) begin
			byte_pos       = POS_X_HIGH;
			samples_done   = '0;
			saw_empty      = 1'b0;
			saw_bad_marker = 1'b0;
			halted         = 1'b0;
		end
		if (halted)
			return;

		case (byte_pos)
			POS_X_HIGH, POS_Y_HIGH, POS_Z_HIGH: high_hold = b;
			POS_X_MID, POS_Y_MID, POS_Z_MID: mid_hold = b;
			default: begin
				if (b[EmptyMarkBit])
					saw_empty = 1'b1;
				if (byte_pos == POS_X_LOW) begin
					if (!b[XAxisMarkBit])
						saw_bad_marker = 1'b1;
					x_hold = axis_value(high_hold, mid_hold, b);
				end else begin
					if (b[XAxisMarkBit])
						saw_bad_marker = 1'b1;
					if (byte_pos == POS_Y_LOW)
						y_hold = axis_value(high_hold, mid_hold, b);
				end
			end
		endcase

		if (byte_pos != POS_Z_LOW) begin
			byte_pos = byte_pos + 1'b1;
			return;
		end

		// The group is complete: empty entries win over wrong axis markers.
		st = STATUS_OK;
		if (mode_fifo) begin
			if (saw_empty)
				st = STATUS_NO_DATA;
			else if (saw_bad_marker)
				st = STATUS_INVALID;
		end
		s.status       = st;
		s.sample_index = samples_done[4:0];
		if (st == STATUS_OK) begin
			s.x_accel = x_hold;
			s.y_accel = y_hold;
			s.z_accel = axis_value(high_hold, mid_hold, b);
		end else begin
			s.x_accel = '0;
			s.y_accel = '0;
			s.z_accel = '0;
		end
		expected_samples.push_back(s);
		waiting++;

		byte_pos       = POS_X_HIGH;
		saw_empty      = 1'b0;
		saw_bad_marker = 1'b0;
		samples_done   = samples_done + 1'b1;
		if (st != STATUS_OK || !mode_fifo || samples_done >= burst_limit(limit_raw))
			halted = 1'b1;
	endtask

	task automatic check_sample(input out_word_t got);
		out_word_t want;
		if (expected_samples.size() == 0) begin
			report_mismatch("unexpected sample word, index", got.sample_index, -1);
			return;
		end
		want = expected_samples.pop_front();
		waiting--;
		if (got.x_accel !== want.x_accel)
			report_mismatch("x_accel", got.x_accel, want.x_accel);
		if (got.y_accel !== want.y_accel)
			report_mismatch("y_accel", got.y_accel, want.y_accel);
		if (got.z_accel !== want.z_accel)
			report_mismatch("z_accel", got.z_accel, want.z_accel);
		if (got.status !== want.status)
			report_mismatch("status", got.status, want.status);
		if (got.sample_index !== want.sample_index)
			report_mismatch("sample_index", got.sample_index, want.sample_index);
	endtask

	// Register writes update the copies; register reads are checked against them.
	task automatic track_register(input logic write, input logic [ApbAddrW-1:0] addr,
		input logic [ApbDataW-1:0] wdata, input logic [ApbDataW-1:0] rdata);
		logic [ApbDataW-1:0] want;
		if (addr[ApbAddrW-1:2] == REG_FIFO_MODE) begin
			if (write)
				mode_fifo = wdata[0];
			want = ApbDataW'(mode_fifo);
		end else begin
			if (write)
				limit_raw = wdata[CountW-1:0];
			want = ApbDataW'(limit_raw);
		end
		if (!write && rdata !== want)
			report_mismatch("register read", int'(rdata), int'(want));
	endtask

	// Outputs are handled before inputs: a word leaving now came from an earlier byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_fifo      = 1'b1;
			limit_raw      = SAMPLE_LIMIT_RESET;
			byte_pos       = POS_X_HIGH;
			high_hold      = '0;
			mid_hold       = '0;
			x_hold         = '0;
			y_hold         = '0;
			saw_empty      = 1'b0;
			saw_bad_marker = 1'b0;
			halted         = 1'b1;
			samples_done   = '0;
			expected_samples.delete();
			waiting        = 0;
		end else begin
			if (out_valid && out_ready)
				check_sample(out_word);
			if (psel && penable && pready)
				track_register(pwrite, paddr, pwdata, prdata);
			if (in_valid && in_ready)
				decode_byte(in_word);
		end
	end

endmodule

### sim/accel_fifo_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// accel_fifo_frame_decoder_tb: stimulus and verdict for the frame decoder
// Drives directed bursts with extreme axis values and marker errors, then
// random well-formed bursts with injected errors, cut groups and stray
// bytes, under several register settings and with random stalls on both
// channels. A separate checker predicts and compares every sample word.
// ------------------------------------------------------------------------
module accel_fifo_frame_decoder_tb;
	import afd_pkg::*;

	localparam logic [ApbAddrW-1:0] AddrFifoMode    = {REG_FIFO_MODE, 2'b00};
	localparam logic [ApbAddrW-1:0] AddrSampleLimit = {REG_SAMPLE_LIMIT, 2'b00};

	// Ways a group's third bytes can be spoiled.
	typedef enum int {
		FLAW_NONE,
		FLAW_EMPTY,
		FLAW_MARKER,
		FLAW_BOTH,
		FLAW_RANDOM
	} flaw_e;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_word_t            in_word;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_word_t           out_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;
	int                  failures;
	int                  pending;

	int burst_left  = 0;
	int sent_bytes  = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	accel_fifo_frame_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	afd_sample_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// The sample receiver stalls in phases: always ready, random, mostly stalled, periodic.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 160);
		end
		stall_left--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((stall_left % 8) < 5);
		endcase
	end

	// Bytes favor the extremes now and then.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Send one byte; bursts of back-to-back words are separated by random gaps.
	task automatic push_byte(input logic [7:0] data, input logic start);
		int       gap;
		in_word_t w;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		w.data_byte   = data;
		w.burst_start = start;
		@(negedge clk);
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		sent_bytes++;
	endtask

	// Hold off the byte channel until every predicted sample has been read.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic apb_access(input logic write, input logic [ApbAddrW-1:0] addr,
		input logic [ApbDataW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic fifo, input logic [CountW-1:0] limit);
		apb_access(1'b1, AddrFifoMode, ApbDataW'(fifo));
		apb_access(1'b1, AddrSampleLimit, ApbDataW'(limit));
		apb_access(1'b0, AddrFifoMode, '0);
		apb_access(1'b0, AddrSampleLimit, '0);
	endtask

	// One nine-byte x,y,z group; the x entry carries the x marker unless spoiled.
	task automatic send_group(input logic start, input flaw_e flaw, input int flaw_axis);
		logic [7:0] low;
		for (int axis = 0; axis < 3; axis++) begin
			low = pick_byte();
			if (flaw != FLAW_RANDOM) begin
				low[XAxisMarkBit] = (axis == 0);
				low[EmptyMarkBit] = 1'b0;
				if (axis == flaw_axis) begin
					if (flaw == FLAW_EMPTY || flaw == FLAW_BOTH)
						low[EmptyMarkBit] = 1'b1;
					if (flaw == FLAW_MARKER || flaw == FLAW_BOTH)
						low[XAxisMarkBit] = ~low[XAxisMarkBit];
				end
			end
			push_byte(pick_byte(), start && axis == 0);
			push_byte(pick_byte(), 1'b0);
			push_byte(low, 1'b0);
		end
	endtask

	// A burst of groups; an error ends it, as the decoder then ignores the rest.
	task automatic run_burst(input int max_groups, input logic fifo);
		int    groups;
		flaw_e flaw;
		groups = $urandom_range(1, max_groups);
		for (int g = 0; g < groups; g++) begin
			if (!fifo)
				flaw = FLAW_RANDOM;
			else if ($urandom_range(0, 7) == 0)
				flaw = flaw_e'($urandom_range(FLAW_EMPTY, FLAW_BOTH));
			else
				flaw = FLAW_NONE;
			send_group(g == 0, flaw, $urandom_range(0, 2));
			if (flaw != FLAW_NONE)
				break;
		end
		// Now and then stray bytes follow, or a lone burst start leaves a cut group.
		case ($urandom_range(0, 5))
			0: repeat ($urandom_range(1, 8)) push_byte(pick_byte(), 1'b0);
			1: push_byte(pick_byte(), 1'b1);
			default: ;
		endcase
	endtask

	task automatic run_phase(input logic fifo, input logic [CountW-1:0] limit, input int quota);
		int first_byte;
		int eff;
		drain_results();
		set_config(fifo, limit);
		eff = (limit == 0) ? 1 : (limit > MaxBurstSamples) ? MaxBurstSamples : int'(limit);
		first_byte = sent_bytes;
		do
			run_burst((eff < 4) ? eff + 1 : 5, fifo);
		while (sent_bytes - first_byte < quota);
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_word  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Reset values of both registers.
		apb_access(1'b0, AddrFifoMode, '0);
		apb_access(1'b0, AddrSampleLimit, '0);

		// Most negative x, largest y, z of minus one; all markers correct.
		push_byte(8'h80, 1'b1); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
		push_byte(8'h7F, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hF0, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hF0, 1'b0);
		// Empty x entry without its marker and an x marker on y: no data wins.
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0);
		push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0); push_byte(8'h51, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h0C, 1'b0);
		// Halted byte, then a burst start that the next burst cuts off.
		push_byte(8'hAA, 1'b0);
		push_byte(8'h5A, 1'b1);

		// A limit beyond the maximum saturates: the 33rd group is ignored.
		drain_results();
		set_config(1'b1, 6'd63);
		for (int g = 0; g < MaxBurstSamples + 1; g++) begin
			send_group(g == 0, FLAW_NONE, 0);
			if (g == MaxBurstSamples / 2)
				drain_results();
		end

		run_phase(1'b1, 6'd3, 60);
		run_phase(1'b0, 6'd32, 50);
		run_phase(1'b1, 6'd0, 40);
		run_phase(1'b0, 6'd1, 30);
		run_phase(1'b1, 6'd33, 550 - sent_bytes);

		drain_results();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### accel_fifo_frame_decoder.f
design/afd_pkg.sv
design/afd_cfg_regs.sv
design/afd_unpack.sv
design/afd_out_reg.sv
design/accel_fifo_frame_decoder.sv
sim/afd_sample_checker.sv
sim/accel_fifo_frame_decoder_tb.sv
